// ===== hdl/spk_pkg.sv =====
`timescale 1ns / 1ps

package spk_pkg;

    // Word and cipher geometry
    localparam int WORD_W          = 64;
    localparam int ROT_ALPHA       = 8;
    localparam int ROT_BETA        = 3;
    localparam int ROUND_COUNT_DEF = 34;

    // Configuration port geometry
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0] word_t;

    // Register indexes of the configuration port; the last index maps to nothing
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3,
        REG_IV_X,
        REG_IV_Y,
        REG_MODE,
        REG_NONE
    } cfg_reg_t;

    // Control handed to the shared round unit
    typedef struct packed {
        logic decrypt;
    } round_ctrl_t;

    function automatic word_t rotr_alpha(input word_t v);
        rotr_alpha = {v[ROT_ALPHA-1:0], v[WORD_W-1:ROT_ALPHA]};
    endfunction

    function automatic word_t rotl_alpha(input word_t v);
        rotl_alpha = {v[WORD_W-ROT_ALPHA-1:0], v[WORD_W-1:WORD_W-ROT_ALPHA]};
    endfunction

    function automatic word_t rotr_beta(input word_t v);
        rotr_beta = {v[ROT_BETA-1:0], v[WORD_W-1:ROT_BETA]};
    endfunction

    function automatic word_t rotl_beta(input word_t v);
        rotl_beta = {v[WORD_W-ROT_BETA-1:0], v[WORD_W-1:WORD_W-ROT_BETA]};
    endfunction

endpackage

// ===== hdl/spk_ram.sv =====
`timescale 1ns / 1ps

module spk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 34,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/spk_round.sv =====
`timescale 1ns / 1ps

module spk_round (
    input  spk_pkg::word_t       x,
    input  spk_pkg::word_t       y,
    input  spk_pkg::word_t       rk,
    input  spk_pkg::round_ctrl_t ctrl,
    output spk_pkg::word_t       nx,
    output spk_pkg::word_t       ny
);
    import spk_pkg::*;

    word_t enc_x;
    word_t enc_y;
    word_t dec_y;
    word_t dec_x;

    // Forward round: one add; also serves the key schedule step
    assign enc_x = (rotr_alpha(x) + y) ^ rk;
    assign enc_y = rotl_beta(y) ^ enc_x;

    // Inverse round: one subtract
    assign dec_y = rotr_beta(x ^ y);
    assign dec_x = rotl_alpha((x ^ rk) - dec_y);

    assign nx = ctrl.decrypt ? dec_x : enc_x;
    assign ny = ctrl.decrypt ? dec_y : enc_y;

endmodule

// ===== hdl/speck128_256_cbc_engine_top.sv =====
// Speck128/256 CBC engine, one shared round unit stepped by a small sequencer.
// Key expansion runs on the first item after reset or a key write, ahead of its rounds.
// Items go one at a time through the single round unit; a new item is accepted only after
// the last result has entered the output register, once that register is free.
// Reset (rst_n, async, active low) clears all registers, the chain and the key-ready flag;
// the round key memory is not cleared and is always filled before it is read.
`timescale 1ns / 1ps

module speck128_256_cbc_engine_top #(
    parameter int ROUND_COUNT = spk_pkg::ROUND_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_write_en,
    input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  spk_pkg::word_t            cfg_data,
    // Input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  spk_pkg::word_t            word_x,
    input  spk_pkg::word_t            word_y,
    input  logic                      chain_restart,
    // Output channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output spk_pkg::word_t            out_x,
    output spk_pkg::word_t            out_y
);
    import spk_pkg::*;

    localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ROUND_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    word_t key0_reg, key1_reg, key2_reg, key3_reg;
    word_t iv_x_reg, iv_y_reg;
    logic  mode_reg;
    logic  keys_ready_reg, keys_ready_next;

    // Chain and working block
    word_t chain_x_reg, chain_x_next, chain_y_reg, chain_y_next;
    word_t cx_reg, cx_next, cy_reg, cy_next;
    word_t x_reg, x_next, y_reg, y_next;

    // Key schedule words: la is the l word used this step
    word_t la_reg, la_next, lb_reg, lb_next, lc_reg, lc_next;
    word_t k_reg, k_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] addr_reg, addr_next;

    logic  out_valid_reg, out_valid_next;
    word_t out_x_reg, out_x_next, out_y_reg, out_y_next;

    // Shared unit and memory hookup
    word_t       ru_x, ru_y, ru_rk, ru_nx, ru_ny;
    round_ctrl_t ru_ctrl;
    word_t       rk_rdata;
    logic        ram_we;
    logic        accept;
    logic        out_free;
    logic        key_write;
    word_t       sel_cx, sel_cy;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign key_write = cfg_write_en && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                        cfg_index == REG_KEY2 || cfg_index == REG_KEY3);
    assign sel_cx    = chain_restart ? iv_x_reg : chain_x_reg;
    assign sel_cy    = chain_restart ? iv_y_reg : chain_y_reg;
    assign ram_we    = (state_reg == ST_EXPAND);

    // Route the shared round unit: key schedule step or cipher round
    always_comb
    begin
        if (state_reg == ST_EXPAND)
        begin
            ru_x         = la_reg;
            ru_y         = k_reg;
            ru_rk        = WORD_W'(cnt_reg);
            ru_ctrl.decrypt = 1'b0;
        end
        else
        begin
            ru_x         = x_reg;
            ru_y         = y_reg;
            ru_rk        = rk_rdata;
            ru_ctrl.decrypt = mode_reg;
        end
    end

    spk_round u_round (
        .x    (ru_x),
        .y    (ru_y),
        .rk   (ru_rk),
        .ctrl (ru_ctrl),
        .nx   (ru_nx),
        .ny   (ru_ny)
    );

    spk_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (ROUND_COUNT),
        .ADDR_W (CNT_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (k_reg),
        .raddr (addr_reg),
        .rdata (rk_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        chain_x_next    = chain_x_reg;
        chain_y_next    = chain_y_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        lc_next         = lc_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Pick the chain, pre-whiten for encryption, keep the input block
                    chain_x_next = sel_cx;
                    chain_y_next = sel_cy;
                    cx_next      = word_x;
                    cy_next      = word_y;
                    x_next       = mode_reg ? word_x : (word_x ^ sel_cx);
                    y_next       = mode_reg ? word_y : (word_y ^ sel_cy);
                    la_next      = key0_reg;
                    lb_next      = key1_reg;
                    lc_next      = key2_reg;
                    k_next       = key3_reg;
                    cnt_next     = '0;
                    addr_next    = mode_reg ? LAST_IDX : '0;
                    state_next   = keys_ready_reg ? ST_PREP : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                // Store current k, rotate l words, advance schedule
                la_next = lb_reg;
                lb_next = lc_reg;
                lc_next = ru_nx;
                k_next  = ru_ny;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next        = '0;
                    keys_ready_next = 1'b1;
                    state_next      = ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                // First key read is in flight; point at the next one
                addr_next  = mode_reg ? (addr_reg - 1'b1) : (addr_reg + 1'b1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                x_next = ru_nx;
                y_next = ru_ny;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    addr_next = mode_reg ? (addr_reg - 1'b1) : (addr_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free, then emit and update chain
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg)
                    begin
                        out_x_next   = x_reg ^ chain_x_reg;
                        out_y_next   = y_reg ^ chain_y_reg;
                        chain_x_next = cx_reg;
                        chain_y_next = cy_reg;
                    end
                    else
                    begin
                        out_x_next   = x_reg;
                        out_y_next   = y_reg;
                        chain_x_next = x_reg;
                        chain_y_next = y_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop the expanded keys on any key register write
        if (key_write)
        begin
            keys_ready_next = 1'b0;
        end
    end

    // State, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            iv_x_reg       <= '0;
            iv_y_reg       <= '0;
            mode_reg       <= 1'b0;
            chain_x_reg    <= '0;
            chain_y_reg    <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            la_reg         <= '0;
            lb_reg         <= '0;
            lc_reg         <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            addr_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            chain_x_reg    <= chain_x_next;
            chain_y_reg    <= chain_y_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            la_reg         <= la_next;
            lb_reg         <= lb_next;
            lc_reg         <= lc_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            addr_reg       <= addr_next;
            out_valid_reg  <= out_valid_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_KEY0: key0_reg <= cfg_data;
                    REG_KEY1: key1_reg <= cfg_data;
                    REG_KEY2: key2_reg <= cfg_data;
                    REG_KEY3: key3_reg <= cfg_data;
                    REG_IV_X: iv_x_reg <= cfg_data;
                    REG_IV_Y: iv_y_reg <= cfg_data;
                    REG_MODE: mode_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    // Rounds never start on a stale key schedule
    a_keys_before_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |-> keys_ready_reg)
        else $error("round pass started without expanded keys");

    // Key memory is written only while the schedule is being rebuilt
    a_write_only_stale: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !keys_ready_reg)
        else $error("key memory written while keys are current");

    // One item at a time: input closes right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item accepted while one is in flight");

    // Finishing with a free output register always produces a result
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item did not reach the output register");

    // The round counter stays within the round range during rounds and key expansion
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND || state_reg == ST_EXPAND) |-> cnt_reg <= LAST_IDX)
        else $error("round counter out of range");

endmodule
